// ----- hdl/rc_channel_change_trigger_macros.svh -----
// Assertion helpers shared by the channel change trigger RTL.
`ifndef RC_CHANNEL_CHANGE_TRIGGER_MACROS_SVH
`define RC_CHANNEL_CHANGE_TRIGGER_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define RCCT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent implies consequent in the next cycle.
`define RCCT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/rcct_pkg.sv -----
package rcct_pkg;

	// Number of monitored slots and the derived index width.
	localparam int SLOTS      = 8;
	localparam int SLOT_IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	// Payload field widths.
	localparam int SLOT_W     = 3;
	localparam int VALUE_W    = 16;
	localparam int TIME_W     = 32;
	localparam int COUNT_W    = 4;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 16;

	// Register reset values.
	localparam logic [COUNT_W-1:0] SLOT_COUNT_RST = '0;
	localparam logic [VALUE_W-1:0] THRESHOLD_RST  = 16'd20;
	localparam logic [VALUE_W-1:0] PERSIST_RST    = 16'd100;
	localparam logic [VALUE_W-1:0] HOLDOFF_RST    = 16'd1000;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SLOT_COUNT       = 4'd0,
		CFG_CHANGE_THRESHOLD = 4'd1,
		CFG_PERSIST_MS       = 4'd2,
		CFG_HOLDOFF_MS       = 4'd3
	} cfg_idx_t;

endpackage

// ----- hdl/rcct_if.sv -----
// Sample channel: one channel reading per transfer.
interface rcct_smp_if;
	import rcct_pkg::*;
	logic               valid;
	logic               ready;
	logic [SLOT_W-1:0]  slot;
	logic [VALUE_W-1:0] sample_value;
	logic [TIME_W-1:0]  now_ms;
	modport source (output valid, slot, sample_value, now_ms, input ready);
	modport sink   (input valid, slot, sample_value, now_ms, output ready);
endinterface

// Trigger channel: one fired slot per transfer.
interface rcct_trg_if;
	import rcct_pkg::*;
	logic               valid;
	logic               ready;
	logic [SLOT_W-1:0]  fired_slot;
	logic [VALUE_W-1:0] fired_value;
	modport source (output valid, fired_slot, fired_value, input ready);
	modport sink   (input valid, fired_slot, fired_value, output ready);
endinterface

// Configuration write channel.
interface rcct_cfg_if;
	import rcct_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ----- hdl/rc_channel_change_trigger.sv -----
// Persistent change detector for RC channel slots, with a per-slot hold-off.
//
// Channels: smp carries one sample (slot, sample_value, now_ms) per transfer;
// trg carries one trigger (fired_slot, fired_value) per qualifying sample;
// cfg writes registers 0..3 (slot_count, change_threshold, persist_ms,
// holdoff_ms). Writes to other indexes are taken and ignored. cfg is always
// ready and should be written only while the block is idle.
//
// A sample is registered on transfer and evaluated in the next cycle; a
// trigger passes through the output register and is then visible on trg.
// Throughput: one sample per cycle while no firing sample waits behind an
// untaken trigger. The per-slot state is read and updated as the sample
// retires, so samples of the same slot may follow each other with no gap.
//
// Stalls: a sample that fires waits in the input register while the output
// register still holds an untaken trigger; samples that do not fire pass on.
// Reset clears all slot baselines, change flags and last-fire times (to
// zero) and loads the register defaults; the block is ready at once.
`include "rc_channel_change_trigger_macros.svh"

module rc_channel_change_trigger (
	input logic        clk,
	input logic        arst_n,
	rcct_smp_if.sink   smp,
	rcct_trg_if.source trg,
	rcct_cfg_if.sink   cfg
);
	import rcct_pkg::*;

	// Configuration registers.
	logic [COUNT_W-1:0] slot_count_q;
	logic [VALUE_W-1:0] threshold_q;
	logic [VALUE_W-1:0] persist_q;
	logic [VALUE_W-1:0] holdoff_q;

	// Per-slot state.
	logic [VALUE_W-1:0] baseline_q    [SLOTS];
	logic [SLOTS-1:0]   base_valid_q;
	logic [SLOTS-1:0]   active_q;
	logic [TIME_W-1:0]  start_time_q  [SLOTS];
	logic [TIME_W-1:0]  last_fire_q   [SLOTS];

	// Input register.
	logic               valid_s1;
	logic [SLOT_W-1:0]  slot_s1;
	logic [VALUE_W-1:0] value_s1;
	logic [TIME_W-1:0]  now_s1;

	// Output register.
	logic               out_valid_q;
	logic [SLOT_W-1:0]  fired_slot_q;
	logic [VALUE_W-1:0] fired_value_q;

	// Evaluation signals.
	logic [SLOT_IDX_W-1:0] idx;
	logic                  slot_used;
	logic [VALUE_W-1:0]    base_eff;
	logic [VALUE_W-1:0]    diff;
	logic                  big;
	logic [TIME_W-1:0]     since_start;
	logic [TIME_W-1:0]     since_fire;
	logic                  fire;
	logic                  advance;
	logic                  smp_xfer;

	// Configuration writes; the port never stalls.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_count_q <= SLOT_COUNT_RST;
			threshold_q  <= THRESHOLD_RST;
			persist_q    <= PERSIST_RST;
			holdoff_q    <= HOLDOFF_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_SLOT_COUNT:       slot_count_q <= cfg.data[COUNT_W-1:0];
				CFG_CHANGE_THRESHOLD: threshold_q  <= cfg.data[VALUE_W-1:0];
				CFG_PERSIST_MS:       persist_q    <= cfg.data[VALUE_W-1:0];
				CFG_HOLDOFF_MS:       holdoff_q    <= cfg.data[VALUE_W-1:0];
				default: ;
			endcase
		end
	end

	// Evaluate the registered sample against its slot state.
	always_comb begin
		idx         = slot_s1[SLOT_IDX_W-1:0];
		slot_used   = ({1'b0, slot_s1} < slot_count_q) && (32'(slot_s1) < SLOTS);
		base_eff    = base_valid_q[idx] ? baseline_q[idx] : value_s1;
		diff        = (value_s1 >= base_eff) ? (value_s1 - base_eff)
		                                      : (base_eff - value_s1);
		big         = diff > threshold_q;
		since_start = now_s1 - start_time_q[idx];
		since_fire  = now_s1 - last_fire_q[idx];
		fire        = valid_s1 && slot_used && big && active_q[idx]
		              && (since_start >= {16'b0, persist_q})
		              && (since_fire >= {16'b0, holdoff_q});
	end

	// A sample leaves the input register unless its trigger has nowhere to go.
	assign advance   = valid_s1 && (!fire || !out_valid_q || trg.ready);
	assign smp.ready = !valid_s1 || advance;
	assign smp_xfer  = smp.valid && smp.ready;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (smp_xfer) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (smp_xfer) begin
			slot_s1  <= smp.slot;
			value_s1 <= smp.sample_value;
			now_s1   <= smp.now_ms;
		end
	end

	// Slot state update when the sample is retired.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_valid_q <= '0;
			active_q     <= '0;
			for (int i = 0; i < SLOTS; i++) begin
				baseline_q[i]  <= '0;
				last_fire_q[i] <= '0;
			end
		end else if (advance && slot_used) begin
			base_valid_q[idx] <= 1'b1;
			if (!big || fire) begin
				baseline_q[idx] <= value_s1;
				active_q[idx]   <= 1'b0;
			end else if (!active_q[idx]) begin
				active_q[idx] <= 1'b1;
			end
			if (fire) begin
				last_fire_q[idx] <= now_s1;
			end
		end
	end

	// Change start time has no reset; it is read only while the change is active.
	always_ff @(posedge clk) begin
		if (advance && slot_used && big && !active_q[idx]) begin
			start_time_q[idx] <= now_s1;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && fire) begin
			out_valid_q <= 1'b1;
		end else if (trg.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && fire) begin
			fired_slot_q  <= slot_s1;
			fired_value_q <= value_s1;
		end
	end

	assign trg.valid       = out_valid_q;
	assign trg.fired_slot  = fired_slot_q;
	assign trg.fired_value = fired_value_q;

	// A retired trigger appears in the output register with its slot and value.
	`RCCT_ASSERT_NEXT(a_fire_loads_out, clk, arst_n, advance && fire,
		out_valid_q && fired_slot_q == $past(slot_s1) && fired_value_q == $past(value_s1),
		"trigger not loaded into output register")

	// The sample side stalls only behind a firing sample and an untaken trigger.
	`RCCT_ASSERT_SAME(a_stall_cause, clk, arst_n, !smp.ready,
		valid_s1 && fire && out_valid_q && !trg.ready,
		"sample channel stalled without a blocked trigger")

	// A slot outside the configured count never fires.
	`RCCT_ASSERT_SAME(a_unused_silent, clk, arst_n, valid_s1 && !slot_used, !fire,
		"unused slot produced a trigger")

	// A fired slot has its change cleared afterwards.
	`RCCT_ASSERT_NEXT(a_fire_clears, clk, arst_n, advance && fire,
		!active_q[$past(idx)] && base_valid_q[$past(idx)],
		"change flag not cleared after trigger")

endmodule

// ----- test/rc_channel_change_trigger_check.sv -----
`timescale 1ns / 1ps

// Watches the sample, trigger and register channels of the change trigger.
// It predicts the triggers and compares each trigger transfer with the oldest
// prediction still waiting.
module rc_channel_change_trigger_check
	import rcct_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	rcct_smp_if  smp,
	rcct_trg_if  trg,
	rcct_cfg_if  cfg,
	output int   fail_count,
	output int   pending
);

	typedef struct packed {
		logic [SLOT_W-1:0]  slot;
		logic [VALUE_W-1:0] value;
	} trigger_t;

	trigger_t expected_triggers[$];
	trigger_t want;

	// Register copy.
	logic [COUNT_W-1:0] slot_count;
	logic [VALUE_W-1:0] threshold;
	logic [VALUE_W-1:0] persist_ms;
	logic [VALUE_W-1:0] holdoff_ms;

	// Per-slot detector state.
	logic [VALUE_W-1:0] baseline     [SLOTS];
	logic               baseline_set [SLOTS];
	logic               changing     [SLOTS];
	logic [TIME_W-1:0]  open_time    [SLOTS];
	logic [TIME_W-1:0]  last_fire    [SLOTS];

	task automatic report_mismatch(input string what);
		$display("%0t ns: mismatch: %s", $time, what);
		fail_count++;
	endtask

	// Updates the slot state for one sample and queues the trigger it causes.
	task automatic predict_trigger(input logic [SLOT_W-1:0] s, input logic [VALUE_W-1:0] v,
		input logic [TIME_W-1:0] now);
		int unsigned        in_use;
		logic [VALUE_W-1:0] delta;
		logic [TIME_W-1:0]  since_start;
		logic [TIME_W-1:0]  since_fire;
		trigger_t           fired;
		in_use = (slot_count > SLOTS) ? SLOTS : slot_count;
		if (s >= in_use) begin
			return;
		end
		if (!baseline_set[s]) begin
			baseline[s] = v;
			baseline_set[s] = 1'b1;
		end
		delta = (v >= baseline[s]) ? v - baseline[s] : baseline[s] - v;
		since_start = now - open_time[s];
		since_fire = now - last_fire[s];
		if (delta > threshold) begin
			// The sample that opens a change never fires by itself.
			if (!changing[s]) begin
				changing[s] = 1'b1;
				open_time[s] = now;
			end else if (since_start >= persist_ms && since_fire >= holdoff_ms) begin
				last_fire[s] = now;
				baseline[s] = v;
				changing[s] = 1'b0;
				fired.slot = s;
				fired.value = v;
				expected_triggers.push_back(fired);
			end
		end else begin
			changing[s] = 1'b0;
			baseline[s] = v;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_count = SLOT_COUNT_RST;
			threshold = THRESHOLD_RST;
			persist_ms = PERSIST_RST;
			holdoff_ms = HOLDOFF_RST;
			for (int i = 0; i < SLOTS; i++) begin
				baseline[i] = '0;
				baseline_set[i] = 1'b0;
				changing[i] = 1'b0;
				open_time[i] = '0;
				last_fire[i] = '0;
			end
			expected_triggers.delete();
			fail_count = 0;
			pending <= 0;
		end else begin
			// Register writes; unmapped indexes are dropped.
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_SLOT_COUNT:       slot_count = cfg.data[COUNT_W-1:0];
					CFG_CHANGE_THRESHOLD: threshold = cfg.data;
					CFG_PERSIST_MS:       persist_ms = cfg.data;
					CFG_HOLDOFF_MS:       holdoff_ms = cfg.data;
					default: begin
					end
				endcase
			end

			// Sample transfers feed the predictor.
			if (smp.valid && smp.ready) begin
				predict_trigger(smp.slot, smp.sample_value, smp.now_ms);
			end

			// Trigger transfers are compared with the oldest prediction.
			if (trg.valid && trg.ready) begin
				if (expected_triggers.size() == 0) begin
					report_mismatch($sformatf("unexpected trigger slot %0d value %0d",
						trg.fired_slot, trg.fired_value));
				end else begin
					want = expected_triggers.pop_front();
					if (trg.fired_slot !== want.slot) begin
						report_mismatch($sformatf("fired_slot %0d, expected %0d",
							trg.fired_slot, want.slot));
					end
					if (trg.fired_value !== want.value) begin
						report_mismatch($sformatf("fired_value %0d, expected %0d (slot %0d)",
							trg.fired_value, want.value, want.slot));
					end
				end
			end
			pending <= expected_triggers.size();
		end
	end

endmodule

// ----- test/rc_channel_change_trigger_tb.sv -----
`timescale 1ns / 1ps

// Drives samples and register writes into the change trigger and pulls its
// triggers; the check module beside the block does all the comparing.
module rc_channel_change_trigger_tb;
	import rcct_pkg::*;

	localparam int PHASE_ITEMS    = 250;
	localparam int IGNORED_ITEMS  = 30;
	localparam int RAMP_ITEMS     = 48;
	localparam int RX_HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES   = 8;

	// An index with no register behind it; writes to it must be dropped.
	localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_IDX = 4'hC;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   tx_idle_pct = 0;
	int   rx_idle_pct = 0;
	logic rx_hold_go = 1'b0;

	// Settings in force, used only to shape the stimulus.
	logic [COUNT_W-1:0] cur_count;
	logic [VALUE_W-1:0] cur_thr;
	logic [VALUE_W-1:0] cur_persist;
	logic [VALUE_W-1:0] cur_holdoff;

	// Per-slot resting level and the level a change moves toward.
	logic [VALUE_W-1:0] center [SLOTS];
	logic [VALUE_W-1:0] target [SLOTS];
	logic [TIME_W-1:0]  clock_ms;

	rcct_smp_if smp ();
	rcct_trg_if trg ();
	rcct_cfg_if cfg ();

	rc_channel_change_trigger dut (
		.clk    (clk),
		.arst_n (arst_n),
		.smp    (smp),
		.trg    (trg),
		.cfg    (cfg)
	);

	rc_channel_change_trigger_check chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.smp        (smp),
		.trg        (trg),
		.cfg        (cfg),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	// Trigger receiver: random stalls, plus one long hold-off on request.
	initial begin
		int hold_left;
		bit hold_taken;
		hold_left = 0;
		hold_taken = 1'b0;
		trg.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold_go && !hold_taken) begin
				hold_left = RX_HOLD_CYCLES;
				hold_taken = 1'b1;
			end
			if (hold_left > 0) begin
				trg.ready <= 1'b0;
				hold_left--;
			end else begin
				trg.ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	// A level more than the threshold away from the given one.
	function automatic logic [VALUE_W-1:0] shifted(input logic [VALUE_W-1:0] from);
		int unsigned offset;
		offset = cur_thr + 1 + $urandom_range(200);
		return $urandom_range(1) ? VALUE_W'(from + offset) : VALUE_W'(from - offset);
	endfunction

	// One sample transfer, after a random number of idle cycles.
	task automatic send_sample(input logic [SLOT_W-1:0] s, input logic [VALUE_W-1:0] v,
		input logic [TIME_W-1:0] now);
		while ($urandom_range(99) < tx_idle_pct) begin
			smp.valid <= 1'b0;
			@(posedge clk);
		end
		smp.valid <= 1'b1;
		smp.slot <= s;
		smp.sample_value <= v;
		smp.now_ms <= now;
		do @(posedge clk); while (!smp.ready);
	endtask

	// Leaves cfg.valid high so that writes can follow back to back.
	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		do @(posedge clk); while (!cfg.ready);
	endtask

	// Writes every register, the upper bits of the slot count at random.
	task automatic apply_settings(input logic [COUNT_W-1:0] count,
		input logic [VALUE_W-1:0] thr, input logic [VALUE_W-1:0] per,
		input logic [VALUE_W-1:0] hold);
		logic [CFG_DATA_W-1:0] count_word;
		count_word = CFG_DATA_W'($urandom());
		count_word[COUNT_W-1:0] = count;
		put_reg(CFG_SLOT_COUNT, count_word);
		put_reg(CFG_CHANGE_THRESHOLD, thr);
		put_reg(CFG_PERSIST_MS, per);
		put_reg(CFG_HOLDOFF_MS, hold);
		put_reg(CFG_UNMAPPED_IDX, CFG_DATA_W'($urandom()));
		cfg.valid <= 1'b0;
		cur_count = count;
		cur_thr = thr;
		cur_persist = per;
		cur_holdoff = hold;
	endtask

	// Waits until every predicted trigger has arrived and the pipeline is empty.
	task automatic wait_idle();
		smp.valid <= 1'b0;
		repeat (2) @(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Random samples: mostly slots in use, levels that hover, jump and settle.
	task automatic run_phase(input int n_items);
		int                 sent;
		int unsigned        in_use;
		int unsigned        step_max;
		logic [SLOT_W-1:0]  s;
		logic [VALUE_W-1:0] v;
		in_use = (cur_count > SLOTS) ? SLOTS : cur_count;
		step_max = ((cur_persist > cur_holdoff) ? cur_persist : cur_holdoff) / 4 + 4;
		sent = 0;
		while (sent < n_items) begin
			if (in_use == 0 || $urandom_range(9) == 0) begin
				s = SLOT_W'($urandom_range(SLOTS - 1));
			end else begin
				s = SLOT_W'($urandom_range(in_use - 1));
			end
			if (s < in_use || in_use == 0) begin
				sent++;
			end

			// Time mostly moves ahead; now and then it jumps or nears the wrap.
			case ($urandom_range(49))
				0:       clock_ms = $urandom();
				1:       clock_ms = 32'hFFFF_FFFF - $urandom_range(3000);
				default: clock_ms = clock_ms + $urandom_range(step_max);
			endcase

			case ($urandom_range(9))
				0, 1, 2: v = VALUE_W'(center[s] + $urandom_range(cur_thr) - (cur_thr >> 1));
				3, 4, 5, 6, 7: begin
					if ($urandom_range(4) == 0) begin
						target[s] = shifted(center[s]);
					end
					v = VALUE_W'(target[s] + $urandom_range(cur_thr >> 2));
				end
				8: begin
					center[s] = target[s];
					target[s] = shifted(center[s]);
					v = center[s];
				end
				default: begin
					case ($urandom_range(2))
						0:       v = '0;
						1:       v = '1;
						default: v = VALUE_W'($urandom());
					endcase
				end
			endcase
			send_sample(s, v, clock_ms);
		end
		wait_idle();
	endtask

	initial begin
		int k;
		smp.valid <= 1'b0;
		smp.slot <= '0;
		smp.sample_value <= '0;
		smp.now_ms <= '0;
		cfg.valid <= 1'b0;
		cfg.index <= CFG_SLOT_COUNT;
		cfg.data <= '0;
		arst_n <= 1'b0;
		cur_count = SLOT_COUNT_RST;
		cur_thr = THRESHOLD_RST;
		cur_persist = PERSIST_RST;
		cur_holdoff = HOLDOFF_RST;
		clock_ms = '0;
		for (k = 0; k < SLOTS; k++) begin
			center[k] = VALUE_W'($urandom());
			target[k] = shifted(center[k]);
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct = 27;
		rx_idle_pct = 88;

		// With the reset slot count of zero every sample is ignored.
		send_sample(3'd0, 16'd500, 32'd0);
		wait_idle();

		// An oversized slot count acts as all slots.
		apply_settings(4'd15, 16'd20, 16'd100, 16'd1000);
		send_sample(3'd0, 16'd1000, 32'd10);
		send_sample(3'd0, 16'd1010, 32'd20);
		send_sample(3'd0, 16'd1031, 32'd30);
		// Persisted, but the first hold-off still counts from time zero.
		send_sample(3'd0, 16'd1040, 32'd200);
		send_sample(3'd0, 16'd1050, 32'd1000);
		send_sample(3'd7, 16'hFFFF, 32'd1100);
		send_sample(3'd7, 16'd0, 32'd1200);
		send_sample(3'd7, 16'd0, 32'd1299);
		send_sample(3'd7, 16'd0, 32'd1300);
		send_sample(3'd0, 16'd0, 32'd1500);
		send_sample(3'd0, 16'd0, 32'd1600);
		// A difference equal to the threshold clears the change.
		send_sample(3'd0, 16'd1070, 32'd1700);
		wait_idle();

		// Zero persistence: the sample that opens a change still does not fire.
		apply_settings(4'd8, 16'd0, 16'd0, 16'd0);
		send_sample(3'd3, 16'd5, 32'hFFFF_FFFF);
		send_sample(3'd3, 16'd6, 32'hFFFF_FFFF);
		send_sample(3'd3, 16'd6, 32'hFFFF_FFFF);
		send_sample(3'd3, 16'd6, 32'd0);
		wait_idle();

		// Largest settings; slot one is outside a count of one.
		apply_settings(4'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_sample(3'd0, 16'd0, 32'd5);
		send_sample(3'd1, 16'd0, 32'd5);
		send_sample(3'd0, 16'hFFFF, 32'hFFFF_FFFF);
		wait_idle();

		apply_settings(4'd8, 16'd20, 16'd100, 16'd1000);
		run_phase(PHASE_ITEMS);
		apply_settings(4'd3, 16'd0, 16'd0, 16'd0);
		run_phase(PHASE_ITEMS);
		apply_settings(4'd15, 16'd300, 16'd50, 16'd200);
		run_phase(PHASE_ITEMS);

		tx_idle_pct = 88;
		rx_idle_pct = 27;
		apply_settings(4'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		run_phase(IGNORED_ITEMS);
		apply_settings(4'd8, 16'hFFFE, 16'hFFFF, 16'hFFFF);
		run_phase(PHASE_ITEMS);
		apply_settings(4'd5, 16'd1000, 16'd1, 16'hFFFF);
		run_phase(PHASE_ITEMS);

		// Rising ramps fire on every other visit while the receiver holds off,
		// so the output register fills and the sample input stalls.
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		apply_settings(4'd8, 16'd0, 16'd0, 16'd0);
		rx_hold_go <= 1'b1;
		for (k = 0; k < RAMP_ITEMS; k++) begin
			clock_ms = clock_ms + 1;
			send_sample(SLOT_W'(k % SLOTS), VALUE_W'((k / SLOTS) * 1000 + 7), clock_ms);
		end
		wait_idle();

		apply_settings(4'd8, 16'd5, 16'd300, 16'd0);
		run_phase(PHASE_ITEMS);
		apply_settings(COUNT_W'($urandom_range(1, 15)), VALUE_W'($urandom_range(100)),
			VALUE_W'($urandom_range(500)), VALUE_W'($urandom_range(2000)));
		run_phase(PHASE_ITEMS);
		apply_settings(4'd1, 16'd10, 16'd20, 16'd40);
		run_phase(PHASE_ITEMS);

		if (fail_count == 0 && pending == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
